// ===== hdl/qtt_pkg.sv =====
// Shared types and codes for the query text tokenizer.
// Input word and result word layouts, event and token type codes, byte constants.
// No dependencies.
package qtt_pkg;

    localparam int VALUE_BITS = 31;

    localparam logic [7:0] CHAR_QUOTE      = 8'h27;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    localparam logic [1:0] EV_CHAR      = 2'd0;
    localparam logic [1:0] EV_TOKEN_END = 2'd1;
    localparam logic [1:0] EV_END_INPUT = 2'd2;
    localparam logic [1:0] EV_STR_ERROR = 2'd3;

    localparam logic [1:0] TOK_NUMBER = 2'd0;
    localparam logic [1:0] TOK_WORD   = 2'd1;
    localparam logic [1:0] TOK_STRING = 2'd2;
    localparam logic [1:0] TOK_DELIM  = 2'd3;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic [1:0]            event_res;
        logic [1:0]            token_type;
        logic [7:0]            char_value;
        logic [VALUE_BITS-1:0] number_value;
        logic                  last;
    } result_t;

endpackage

// ===== hdl/query_text_tokenizer_top.sv =====
// Query text tokenizer: splits a byte stream into number, word, string and delimiter tokens.
// Depends on qtt_pkg for word layouts and codes.
// The input word is registered in the input register, then its first result word in the
// output register. Throughput: one input word per cycle while result_stall is low; a word
// yielding two results holds the input while the second result drains from the hold register.
// Reset: asynchronous, active low; clears all valid flags, lexer mode and accumulator.
module query_text_tokenizer_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  qtt_pkg::item_t item,
    output logic           result_valid,
    input  logic           result_stall,
    output qtt_pkg::result_t result
);

    localparam int VB = qtt_pkg::VALUE_BITS;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_WORD,
        MODE_STR
    } mode_t;

    function automatic qtt_pkg::result_t mk(
        input logic [1:0]    ev,
        input logic [1:0]    ty,
        input logic [7:0]    cv,
        input logic [VB-1:0] num
    );
        qtt_pkg::result_t r;
        r.event_res    = ev;
        r.token_type   = ty;
        r.char_value   = cv;
        r.number_value = num;
        r.last         = 1'b0;
        return r;
    endfunction

    logic             in_valid_reg, in_valid_next;
    qtt_pkg::item_t   in_reg, in_next;
    mode_t            mode_reg, mode_next;
    logic [VB-1:0]    acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;
    qtt_pkg::result_t out_reg, out_next;
    logic             pend_valid_reg, pend_valid_next;
    qtt_pkg::result_t pend_reg, pend_next;

    logic [7:0]       c;
    logic             is_digit, is_upper, is_lower, is_space, is_word_start, is_quote;
    logic [7:0]       lower_c;
    logic [VB-1:0]    digit_ext;
    logic [VB+3:0]    acc_sum;
    logic [VB-1:0]    acc_sat;

    logic             st_n;
    qtt_pkg::result_t st_res;
    mode_t            st_mode;
    logic [VB-1:0]    st_acc;

    logic [1:0]       n;
    qtt_pkg::result_t r0, r1;
    mode_t            proc_mode;
    logic [VB-1:0]    proc_acc;

    logic             out_free, consume, accept;

    assign c             = in_reg.ch;
    assign is_digit      = (c >= 8'h30) && (c <= 8'h39);
    assign is_upper      = (c >= 8'h41) && (c <= 8'h5A);
    assign is_lower      = (c >= 8'h61) && (c <= 8'h7A);
    assign is_space      = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign is_word_start = is_upper || is_lower || (c == qtt_pkg::CHAR_UNDERSCORE);
    assign is_quote      = (c == qtt_pkg::CHAR_QUOTE);
    assign lower_c       = is_upper ? (c | 8'h20) : c;
    assign digit_ext     = {{(VB-4){1'b0}}, c[3:0]};

    assign acc_sum = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                   + {{VB{1'b0}}, c[3:0]};
    assign acc_sat = (|acc_sum[VB+3:VB]) ? {VB{1'b1}} : acc_sum[VB-1:0];

    always_comb
    begin
        st_n    = 1'b0;
        st_res  = '0;
        st_mode = MODE_IDLE;
        st_acc  = '0;
        priority if (is_space)
        begin
            st_n = 1'b0;
        end
        else if (is_digit)
        begin
            st_n    = 1'b1;
            st_mode = MODE_NUM;
            st_acc  = digit_ext;
            st_res  = mk(qtt_pkg::EV_CHAR, qtt_pkg::TOK_NUMBER, c, digit_ext);
        end
        else if (is_word_start)
        begin
            st_n    = 1'b1;
            st_mode = MODE_WORD;
            st_res  = mk(qtt_pkg::EV_CHAR, qtt_pkg::TOK_WORD, lower_c, '0);
        end
        else if (is_quote)
        begin
            st_mode = MODE_STR;
        end
        else
        begin
            st_n   = 1'b1;
            st_res = mk(qtt_pkg::EV_TOKEN_END, qtt_pkg::TOK_DELIM, c, '0);
        end
    end

    always_comb
    begin
        n         = 2'd0;
        r0        = '0;
        r1        = '0;
        proc_mode = mode_reg;
        proc_acc  = acc_reg;
        if (in_reg.func == qtt_pkg::FUNC_END)
        begin
            proc_mode = MODE_IDLE;
            proc_acc  = '0;
            unique case (mode_reg)
                MODE_STR:
                begin
                    n  = 2'd1;
                    r0 = mk(qtt_pkg::EV_STR_ERROR, qtt_pkg::TOK_STRING, 8'h00, '0);
                end
                MODE_NUM:
                begin
                    n  = 2'd2;
                    r0 = mk(qtt_pkg::EV_TOKEN_END, qtt_pkg::TOK_NUMBER, 8'h00, acc_reg);
                    r1 = mk(qtt_pkg::EV_END_INPUT, qtt_pkg::TOK_NUMBER, 8'h00, '0);
                end
                MODE_WORD:
                begin
                    n  = 2'd2;
                    r0 = mk(qtt_pkg::EV_TOKEN_END, qtt_pkg::TOK_WORD, 8'h00, '0);
                    r1 = mk(qtt_pkg::EV_END_INPUT, qtt_pkg::TOK_NUMBER, 8'h00, '0);
                end
                MODE_IDLE:
                begin
                    n  = 2'd1;
                    r0 = mk(qtt_pkg::EV_END_INPUT, qtt_pkg::TOK_NUMBER, 8'h00, '0);
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        n        = 2'd1;
                        r0       = mk(qtt_pkg::EV_CHAR, qtt_pkg::TOK_NUMBER, c, acc_sat);
                        proc_acc = acc_sat;
                    end
                    else
                    begin
                        n  = 2'(st_n) + 2'd1;
                        r0 = mk(qtt_pkg::EV_TOKEN_END, qtt_pkg::TOK_NUMBER, 8'h00, acc_reg);
                        r1        = st_res;
                        proc_mode = st_mode;
                        proc_acc  = st_acc;
                    end
                end
                MODE_WORD:
                begin
                    if (is_word_start || is_digit)
                    begin
                        n  = 2'd1;
                        r0 = mk(qtt_pkg::EV_CHAR, qtt_pkg::TOK_WORD, lower_c, '0);
                    end
                    else
                    begin
                        n  = 2'(st_n) + 2'd1;
                        r0 = mk(qtt_pkg::EV_TOKEN_END, qtt_pkg::TOK_WORD, 8'h00, '0);
                        r1        = st_res;
                        proc_mode = st_mode;
                        proc_acc  = st_acc;
                    end
                end
                MODE_STR:
                begin
                    n = 2'd1;
                    if (is_quote)
                    begin
                        r0        = mk(qtt_pkg::EV_TOKEN_END, qtt_pkg::TOK_STRING, 8'h00, '0);
                        proc_mode = MODE_IDLE;
                    end
                    else
                    begin
                        r0 = mk(qtt_pkg::EV_CHAR, qtt_pkg::TOK_STRING, c, '0);
                    end
                end
                MODE_IDLE:
                begin
                    n         = {1'b0, st_n};
                    r0        = st_res;
                    proc_mode = st_mode;
                    proc_acc  = st_acc;
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
        end
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign out_free   = !out_valid_reg || !result_stall;
    assign consume    = in_valid_reg && !pend_valid_reg && (out_free || (n == 2'd0));
    assign item_stall = in_valid_reg && !consume;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_next         = in_reg;
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (consume)
        begin
            in_valid_next = 1'b0;
            mode_next     = proc_mode;
            acc_next      = proc_acc;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_next       = item;
        end

        if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        else if (consume && (n != 2'd0))
        begin
            out_valid_next = 1'b1;
            out_next       = r0;
            if (n == 2'd2)
            begin
                pend_valid_next = 1'b1;
                pend_next       = r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_reg         <= '0;
            mode_reg       <= MODE_IDLE;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            in_reg         <= in_next;
            mode_reg       <= mode_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result held without a first result in the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && in_valid_reg) |-> item_stall)
        else $error("input word taken while a second result still waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_NUM) |-> (acc_reg == '0))
        else $error("accumulator not cleared outside a number token");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_reg.event_res == qtt_pkg::EV_END_INPUT)
                           || (out_reg.event_res == qtt_pkg::EV_STR_ERROR)))
        |-> out_reg.last)
        else $error("end of input result not marked last");

endmodule
